[rtl/lpd_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Rangefinder packet deframer package
// Byte codes, packet positions, the packet record and queue sizing shared by
// the deframer modules.
// ----------------------------------------------------------------------------
package lpd_pkg;

  localparam logic [7:0] START_BYTE = 8'hFA;
  localparam logic [7:0] INDEX_LOW  = 8'hA0;
  localparam logic [7:0] INDEX_HIGH = 8'hF9;

  // Phase codes: hunting, awaiting the index byte, then the position of the
  // next packet byte up to the final checksum byte.
  localparam logic [4:0] PH_HUNT        = 5'd0;
  localparam logic [4:0] PH_INDEX       = 5'd1;
  localparam logic [4:0] PH_SPEED_HI    = 5'd3;
  localparam logic [4:0] PH_SAMPLE_FIRST = 5'd4;
  localparam logic [4:0] PH_SAMPLE_LAST = 5'd19;
  localparam logic [4:0] PH_LAST        = 5'd21;

  localparam int FOLD_SHIFT = 15;
  localparam int ACC_W      = 26;
  localparam int SAMPLE_W   = 128;

  localparam int QDEPTH = 2;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // One finished packet, handed from the front end to the result sequencer.
  typedef struct packed {
    logic [6:0]          pkt_index;
    logic [SAMPLE_W-1:0] sample_bytes;
    logic [15:0]         speed_word;
    logic                ok;
    logic [15:0]         good_count;
    logic [15:0]         error_count;
  } lpd_packet_t;

  typedef struct packed {
    logic        valid;
    lpd_packet_t pkt;
  } lpd_push_t;

  typedef struct packed {
    logic        full;
    logic        empty;
  } lpd_qstat_t;

endpackage

[rtl/lpd_in_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Byte input channel
// Valid/ready channel carrying one received serial byte per transfer.
// ----------------------------------------------------------------------------
interface lpd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

[rtl/lpd_out_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sample output channel
// Valid/ready channel carrying one decoded range sample per transfer.
// ----------------------------------------------------------------------------
interface lpd_out_if;
  logic        valid;
  logic        ready;
  logic [8:0]  angle_deg;
  logic [12:0] distance_mm;
  logic [15:0] quality;
  logic [15:0] speed_raw;
  logic        checksum_ok;
  logic [15:0] good_count;
  logic [15:0] error_count;
  logic        last;

  modport source (output valid, output angle_deg, output distance_mm, output quality,
                  output speed_raw, output checksum_ok, output good_count,
                  output error_count, output last, input ready);
  modport sink   (input valid, input angle_deg, input distance_mm, input quality,
                  input speed_raw, input checksum_ok, input good_count,
                  input error_count, input last, output ready);
endinterface

[rtl/lpd_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Deframer front end
// Hunts for packets, gathers fields, runs the checksum and pushes one record
// per completed packet into the queue.
// ----------------------------------------------------------------------------
module lpd_front
  import lpd_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  lpd_in_if.sink     rx,
  input  lpd_qstat_t qstat,
  output lpd_push_t  push
);

  logic [4:0]          phase;
  logic [4:0]          phase_next;
  logic [6:0]          pkt_index;
  logic [SAMPLE_W-1:0] sample_bytes;
  logic [15:0]         speed_word;
  logic [7:0]          low_byte_hold;
  logic [ACC_W-1:0]    acc;
  logic [15:0]         good_counter;
  logic [15:0]         error_counter;

  logic                take;
  logic [15:0]         word;
  logic [ACC_W-1:0]    acc_step;
  logic [14:0]         calc;
  logic                ok;
  logic                index_ok;
  logic [7:0]          index_off;

  // Only the final byte needs room in the queue.
  assign rx.ready = (phase != PH_LAST) || !qstat.full;
  assign take     = rx.valid && rx.ready;

  assign word      = {rx.rx_byte, low_byte_hold};
  assign acc_step  = {acc[ACC_W-2:0], 1'b0} + {{(ACC_W-16){1'b0}}, word};
  assign calc      = acc[FOLD_SHIFT-1:0]
                   + {{(2*FOLD_SHIFT-ACC_W){1'b0}}, acc[ACC_W-1:FOLD_SHIFT]};
  assign ok        = (word == {1'b0, calc});
  assign index_ok  = (rx.rx_byte >= INDEX_LOW) && (rx.rx_byte <= INDEX_HIGH);
  assign index_off = rx.rx_byte - INDEX_LOW;

  always_comb begin
    case (phase)
      PH_HUNT: begin
        phase_next = (rx.rx_byte == START_BYTE) ? PH_INDEX : PH_HUNT;
      end
      PH_INDEX: begin
        phase_next = index_ok ? (PH_INDEX + 5'd1) : PH_HUNT;
      end
      PH_LAST: begin
        phase_next = PH_HUNT;
      end
      default: begin
        phase_next = (phase > PH_LAST) ? PH_HUNT : phase + 5'd1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_HUNT;
      pkt_index     <= '0;
      speed_word    <= '0;
      low_byte_hold <= '0;
      acc           <= '0;
      good_counter  <= '0;
      error_counter <= '0;
    end else if (take) begin
      phase <= phase_next;
      if (phase == PH_HUNT || phase > PH_LAST) begin
        if (rx.rx_byte == START_BYTE) begin
          low_byte_hold <= rx.rx_byte;
          acc           <= '0;
        end
      end else if (phase == PH_INDEX) begin
        if (index_ok) begin
          pkt_index <= index_off[6:0];
          acc       <= acc_step;
        end
      end else if (phase == PH_LAST) begin
        if (ok) begin
          good_counter <= good_counter + 16'd1;
        end else begin
          error_counter <= error_counter + 16'd1;
        end
      end else begin
        if (phase == PH_SPEED_HI) begin
          speed_word <= word;
        end
        if (!phase[0]) begin
          low_byte_hold <= rx.rx_byte;
        end else begin
          acc <= acc_step;
        end
      end
    end
  end

  // Sample bytes shift in from the top, so the first byte ends at bit 0.
  always_ff @(posedge clk) begin
    if (take && phase >= PH_SAMPLE_FIRST && phase <= PH_SAMPLE_LAST) begin
      sample_bytes <= {rx.rx_byte, sample_bytes[SAMPLE_W-1:8]};
    end
  end

  always_comb begin
    push.valid            = take && (phase == PH_LAST);
    push.pkt.pkt_index    = pkt_index;
    push.pkt.sample_bytes = sample_bytes;
    push.pkt.speed_word   = speed_word;
    push.pkt.ok           = ok;
    push.pkt.good_count   = ok ? good_counter + 16'd1 : good_counter;
    push.pkt.error_count  = ok ? error_counter : error_counter + 16'd1;
  end

endmodule

[rtl/lpd_queue.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Packet record queue
// Small register FIFO of finished packets between front end and sequencer.
// ----------------------------------------------------------------------------
module lpd_queue
  import lpd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  lpd_push_t   push,
  input  logic        pop,
  output lpd_packet_t head,
  output lpd_qstat_t  qstat
);

  lpd_packet_t       entries [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;
  logic              do_push;
  logic              do_pop;

  assign qstat.full  = (count == QCNT_W'(QDEPTH));
  assign qstat.empty = (count == '0);
  assign do_push     = push.valid && !qstat.full;
  assign do_pop      = pop && !qstat.empty;
  assign head        = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push.pkt;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

[rtl/lpd_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Result sequencer
// Expands each queued packet record into four samples through an output
// register.
// ----------------------------------------------------------------------------
module lpd_back
  import lpd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  lpd_packet_t head,
  input  lpd_qstat_t  qstat,
  output logic        pop,
  lpd_out_if.source   samples
);

  logic [1:0]  k;
  logic        out_valid;
  logic        load;
  logic [31:0] cur;

  assign load = !qstat.empty && (!out_valid || samples.ready);
  assign pop  = load && (k == 2'd3);
  assign cur  = head.sample_bytes[{k, 5'd0} +: 32];

  assign samples.valid = out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      k         <= '0;
    end else if (load) begin
      out_valid <= 1'b1;
      k         <= k + 2'd1;
    end else if (samples.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      samples.angle_deg   <= {head.pkt_index, k};
      samples.distance_mm <= head.ok ? {cur[12:8], cur[7:0]} : '0;
      samples.quality     <= head.ok ? cur[31:16] : '0;
      samples.speed_raw   <= head.speed_word;
      samples.checksum_ok <= head.ok;
      samples.good_count  <= head.good_count;
      samples.error_count <= head.error_count;
      samples.last        <= (k == 2'd3);
    end
  end

endmodule

[rtl/lidar_packet_deframer_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Rangefinder packet deframer
// Finds 22-byte rangefinder packets in a byte stream, checks their 15-bit
// folded checksum and emits four range samples per packet.
// ----------------------------------------------------------------------------
//
//   Channel   Role     Transfer carries
//   rx        sink     rx_byte: one received serial byte
//   samples   source   angle, distance, quality, speed, checksum flag,
//                      good/bad packet counts, last-of-packet flag
//
// The byte input takes one transfer per cycle. The final byte of a packet
// completes the checksum in the same cycle and pushes a packet record into a
// two-entry queue; the sequencer then sends the four samples on consecutive
// cycles while the sample sink is ready, each loaded into its output register. The
// final byte is held off only while the queue is full; other bytes are never
// stalled. Reset is synchronous and returns the block to hunting with cleared
// counters.
//
module lidar_packet_deframer_top
  import lpd_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  lpd_in_if.sink    rx,
  lpd_out_if.source samples
);

  lpd_push_t   push;
  lpd_qstat_t  qstat;
  lpd_packet_t head;
  logic        pop;

  // The front end walks the packet one byte per transfer and owns the
  // checksum accumulator and the packet counters.
  lpd_front u_front (
    .clk   (clk),
    .rst   (rst),
    .rx    (rx),
    .qstat (qstat),
    .push  (push)
  );

  // Finished packets wait here, so a stalled sample sink does not stop the
  // byte stream until two packets are pending.
  lpd_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .pop   (pop),
    .head  (head),
    .qstat (qstat)
  );

  // The sequencer drains one packet as four sample transfers.
  lpd_back u_back (
    .clk     (clk),
    .rst     (rst),
    .head    (head),
    .qstat   (qstat),
    .pop     (pop),
    .samples (samples)
  );

endmodule

[rtl/lpd_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Deframer port checker
// Concurrent assertions on the sample output of the deframer.
// ----------------------------------------------------------------------------
module lpd_checker (
  input logic       clk,
  input logic       rst,
  lpd_out_if.source samples
);

  a_hold_valid : assert property (@(posedge clk) disable iff (rst)
    samples.valid && !samples.ready |=> samples.valid)
    else $error("sample valid dropped while stalled");

  a_reset_idle : assert property (@(posedge clk)
    rst |=> !samples.valid)
    else $error("sample valid after reset");

  a_last_angle : assert property (@(posedge clk) disable iff (rst)
    samples.valid |-> (samples.last == (samples.angle_deg[1:0] == 2'b11)))
    else $error("last flag does not match sample number");

  a_error_zero : assert property (@(posedge clk) disable iff (rst)
    samples.valid && !samples.checksum_ok |->
      (samples.distance_mm == '0) && (samples.quality == '0))
    else $error("nonzero sample on checksum error");

endmodule

bind lidar_packet_deframer_top lpd_checker u_checker (
  .clk     (clk),
  .rst     (rst),
  .samples (samples)
);
